[rtl/xrg_pkg.sv]
// Shared types, constants and helper functions for the xorshift random generator.
`default_nettype none

package xrg_pkg;

    // Command codes carried by an input transaction
    typedef enum logic [1:0] {
        CMD_MIX    = 2'd0,
        CMD_DRAW   = 2'd1,
        CMD_AROUND = 2'd2
    } cmd_t;

    // One input transaction as held in the input register
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] operand;
    } item_t;

    // One result pushed from the core into the output register
    typedef struct packed {
        logic        push;
        logic [31:0] value;
    } result_t;

    localparam logic [31:0] MIX_MULT  = 32'h0100_0193;
    localparam logic [31:0] ZERO_SEED = 32'd13;
    localparam logic [31:0] MASK_CAP  = 32'h0fff_ffff;
    localparam int          SHIFT_A   = 13;
    localparam int          SHIFT_B   = 17;
    localparam int          SHIFT_C   = 5;

    // One xorshift32 step; a zero seed is replaced first
    function automatic logic [31:0] xs_step(input logic [31:0] seed);
        logic [31:0] x;
        x = (seed == 32'd0) ? ZERO_SEED : seed;
        x = x ^ (x << SHIFT_A);
        x = x ^ (x >> SHIFT_B);
        x = x ^ (x << SHIFT_C);
        return x;
    endfunction

    // Largest 2^k-1 not above v, capped at MASK_CAP
    function automatic logic [31:0] span_mask(input logic [31:0] v);
        logic [27:0] s;
        logic [31:0] m;
        s = v[27:0];
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        if (v[31:28] != 4'd0) begin
            m = MASK_CAP;
        end else if (s == v[27:0]) begin
            m = {4'd0, s};
        end else begin
            m = {5'd0, s[27:1]};
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[rtl/xrg_in_stage.sv]
// Input register: captures one transaction and holds it until the core takes it.
`default_nettype none

module xrg_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [1:0]    s_command,
    input  wire logic [31:0]   s_operand,
    output logic               item_valid,
    output xrg_pkg::item_t     item,
    input  wire logic          item_take
);
    import xrg_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Free when empty or when the held transaction leaves this cycle
    assign s_ready    = !valid_reg || item_take;
    assign valid_next = s_valid || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.command <= s_command;
            item_reg.operand <= s_operand;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[rtl/xrg_core.sv]
// Seed register and the single-pass mix / draw / around datapath.
`default_nettype none

module xrg_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          item_valid,
    input  wire xrg_pkg::item_t item,
    output logic               item_take,
    input  wire logic          out_free,
    output xrg_pkg::result_t   result
);
    import xrg_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] seed_next;
    logic [31:0] draw;
    logic [31:0] mixed;
    logic [31:0] mask;
    logic [31:0] around;
    logic [31:0] value;
    logic        has_res;

    assign draw   = xs_step(seed_reg);
    assign mixed  = seed_reg * MIX_MULT;
    assign mask   = span_mask(item.operand);
    assign around = item.operand - (mask >> 1) + (draw & mask);

    // Command decode
    always_comb begin
        has_res   = 1'b0;
        seed_next = seed_reg;
        value     = draw;
        unique case (cmd_t'(item.command))
            CMD_MIX: begin
                seed_next = mixed ^ item.operand;
            end
            CMD_DRAW: begin
                has_res   = 1'b1;
                seed_next = draw;
            end
            CMD_AROUND: begin
                has_res   = 1'b1;
                seed_next = draw;
                value     = around;
            end
            default: begin
                has_res   = 1'b0;
            end
        endcase
    end

    // A transaction without a result never waits on the output side
    assign item_take    = item_valid && (!has_res || out_free);
    assign result.push  = item_take && has_res;
    assign result.value = value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 32'd0;
        end else if (item_take) begin
            seed_reg <= seed_next;
        end
    end

endmodule

`default_nettype wire

[rtl/xrg_out_stage.sv]
// Output register: holds one result transaction until the consumer takes it.
`default_nettype none

module xrg_out_stage (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire xrg_pkg::result_t result,
    output logic                 out_free,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [31:0]          m_random_value
);
    import xrg_pkg::*;

    logic        valid_reg;
    logic [31:0] data_reg;

    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= result.push;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.push) begin
            data_reg <= result.value;
        end
    end

    assign m_valid        = valid_reg;
    assign m_random_value = data_reg;

endmodule

`default_nettype wire

[rtl/xorshift_random_generator.sv]
// Top level of the xorshift random generator.
//
//  channel | direction | ports                          | payload
//  --------+-----------+--------------------------------+---------------------------
//  s_      | in        | s_valid, s_ready               | s_command[1:0], s_operand[31:0]
//  m_      | out       | m_valid, m_ready               | m_random_value[31:0]
//
// Without a stall on m_, one transaction per cycle is accepted and retired; the seed
// update and the result come from one pass of logic between the input and output
// registers. An accepted transaction is held in the input register, then its result in
// the output register, where m_valid rises; the m_ handshake can follow from then on.
// Mix and unused commands update state (or nothing) and produce no result.
// Reset (aresetn low, synchronous) clears the seed to zero and empties both registers.
// A stall on m_ backs up into s_ready only once both registers are full.
`default_nettype none

module xorshift_random_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [31:0] s_operand,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_random_value
);
    import xrg_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    item_take;
    logic    out_free;
    result_t result;

    xrg_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_operand  (s_operand),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    xrg_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_free   (out_free),
        .result     (result)
    );

    xrg_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .result         (result),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_random_value (m_random_value)
    );

endmodule

`default_nettype wire

[rtl/xrg_checker.sv]
// Port-level checks for the xorshift random generator, bound to the top level.
`default_nettype none

module xrg_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready
);

    // Output register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // Input side only stalls when the output side is backed up
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("s_ready low while output free");

    // A new result is traced back to an accepted transaction through both registers
    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without matching input transaction");

    // A stalled result stays presented
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("m_valid dropped while stalled");

endmodule

bind xorshift_random_generator xrg_checker u_xrg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready)
);

`default_nettype wire
